// ----- src/spring_damper_implicit_step_macros.svh -----
// assertion macros for the spring-damper step block
// used by the top level only, expects clk and rst_n in scope
`ifndef SPRING_DAMPER_IMPLICIT_STEP_MACROS_SVH
`define SPRING_DAMPER_IMPLICIT_STEP_MACROS_SVH

// same-cycle implication
`define SDIS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/sdis_pkg.sv -----
// shared types and constants of the spring-damper step block
// no dependencies
package sdis_pkg;

  localparam int NUM_W = 84;  // signed numerator
  localparam int MAG_W = 82;  // numerator magnitude
  localparam int DET_W = 49;  // determinant, always >= 2^32
  localparam int QUO_W = 50;  // quotient magnitude
  localparam int ACC_W = 96;  // product accumulator
  localparam int SUM_W = 52;  // position plus quotient

  localparam logic REG_ZETA  = 1'b0;
  localparam logic REG_OMEGA = 1'b1;

  typedef enum logic [3:0] {
    OP_HH, OP_HHH, OP_TZ, OP_TZO, OP_OO, OP_HOO, OP_HHOO, OP_TV, OP_DHH, OP_DHO
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    mul_start;
    mul_op_t mul_op;
    logic    num_load;
    logic    div_start;
    logic    div_sel;    // 0 position, 1 velocity
    logic    div_store;
    logic    finish;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
  } dp_stat_t;

endpackage

// ----- src/sdis_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on sdis_pkg
module sdis_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sdis_pkg::MAG_W-1:0]  num_mag,
  input  logic [sdis_pkg::DET_W-1:0]  den,
  output logic                        done,
  output logic [sdis_pkg::QUO_W-1:0]  quo
);
  import sdis_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DET_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] low_r, quo_r;
  logic [DET_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DET_W:0]   shifted;
  logic [DET_W+1:0] diff;
  logic             qbit;

  // top 32 numerator bits are below the divisor, so they preload the remainder
  always_comb begin
    shifted = {rem_r, low_r[QUO_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_r};
    qbit    = !diff[DET_W+1];
    rem_nxt = qbit ? diff[DET_W-1:0] : shifted[DET_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= DET_W'(num_mag[MAG_W-1:QUO_W]);
        low_r  <= num_mag[QUO_W-1:0];
        den_r  <= den;
        quo_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        low_r <= {low_r[QUO_W-2:0], 1'b0};
        quo_r <= {quo_r[QUO_W-2:0], qbit};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

// ----- src/sdis_ctrl.sv -----
// sequencer for the spring-damper step: products, numerators, two divides
// depends on sdis_pkg
module sdis_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output sdis_pkg::dp_cmd_t  cmd,
  input  sdis_pkg::dp_stat_t stat
);
  import sdis_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_GO, S_MUL_WAIT, S_NUM, S_DIVX_GO, S_DIVX_WAIT,
    S_DIVV_GO, S_DIVV_WAIT, S_DONE
  } state_t;

  state_t  state_r;
  mul_op_t op_r;
  logic    out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == S_IDLE) && in_valid;
    cmd.mul_start = (state_r == S_MUL_GO);
    cmd.mul_op    = op_r;
    cmd.num_load  = (state_r == S_NUM);
    cmd.div_start = (state_r == S_DIVX_GO) || (state_r == S_DIVV_GO);
    cmd.div_sel   = (state_r == S_DIVV_GO) || (state_r == S_DIVV_WAIT);
    cmd.div_store = ((state_r == S_DIVX_WAIT) || (state_r == S_DIVV_WAIT)) && stat.div_done;
    cmd.finish    = (state_r == S_DONE) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_HH;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= OP_HH;
            state_r <= S_MUL_GO;
          end
        end
        S_MUL_GO: state_r <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (stat.mul_done) begin
            if (op_r == OP_DHO) begin
              state_r <= S_NUM;
            end else begin
              op_r    <= mul_op_t'(op_r + 4'd1);
              state_r <= S_MUL_GO;
            end
          end
        end
        S_NUM:     state_r <= S_DIVX_GO;
        S_DIVX_GO: state_r <= S_DIVX_WAIT;
        S_DIVX_WAIT: begin
          if (stat.div_done) state_r <= S_DIVV_GO;
        end
        S_DIVV_GO: state_r <= S_DIVV_WAIT;
        S_DIVV_WAIT: begin
          if (stat.div_done) state_r <= S_DONE;
        end
        S_DONE: begin
          if (cmd.finish) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
endmodule

// ----- src/sdis_dp.sv -----
// datapath: shared 32x32 multiplier, coefficient registers, divider, saturation
// depends on sdis_pkg and sdis_div
module sdis_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  sdis_pkg::dp_cmd_t  cmd,
  output sdis_pkg::dp_stat_t stat,
  input  logic signed [31:0] in_position_in,
  input  logic signed [31:0] in_target,
  input  logic [15:0]        in_time_step,
  input  logic [19:0]        zeta,
  input  logic [23:0]        omega,
  output logic signed [31:0] out_position_out,
  output logic signed [31:0] out_velocity_out,
  output logic               out_clamped
);
  import sdis_pkg::*;

  // operands and coefficients
  logic signed [31:0] x_r, vel_r;
  logic [15:0]        h_r, t_r;
  logic [31:0]        h2_r, vmag_r;
  logic [32:0]        dmag_r;
  logic               d_neg_r, v_neg_r;
  logic [35:0]        tz_r;
  logic [DET_W-1:0]   f_r, det_r;
  logic [47:0]        oo_r, hoo_r, hhoo_r;
  logic signed [NUM_W-1:0] tv_r, dh_r, do_r, nx_r, nv_r;

  // multiplier
  mul_op_t      mop_r;
  logic [2:0]   mcnt_r;
  logic         mbusy_r;
  logic [63:0]  a_sel, b_sel;
  logic [31:0]  a_half, b_half;
  logic [63:0]  prod_r;
  logic [1:0]   sh_r;
  logic [ACC_W-1:0] acc_r, pp_ext;
  logic         mul_done;
  logic [49:0]  t48;

  // divide and result
  logic signed [NUM_W-1:0] num_sel, num_abs;
  logic               nneg_r, div_done;
  logic [QUO_W-1:0]   quo;
  logic signed [QUO_W:0] qx_r, qv_r, q_signed;
  logic signed [32:0] dd;
  logic signed [SUM_W-1:0] pos_sum, vel_ext;
  logic               pos_ovf, vel_ovf;
  logic signed [31:0] pos_sat, vel_sat;
  logic signed [31:0] pos_out_r, vel_out_r;
  logic               clamp_r;

  always_comb begin
    case (mop_r)
      OP_HH:   begin a_sel = 64'(h_r);    b_sel = 64'(h_r);    end
      OP_HHH:  begin a_sel = 64'(h2_r);   b_sel = 64'(h_r);    end
      OP_TZ:   begin a_sel = 64'(t_r);    b_sel = 64'(zeta);   end
      OP_TZO:  begin a_sel = 64'(tz_r);   b_sel = 64'(omega);  end
      OP_OO:   begin a_sel = 64'(omega);  b_sel = 64'(omega);  end
      OP_HOO:  begin a_sel = 64'(t_r);    b_sel = 64'(oo_r);   end
      OP_HHOO: begin a_sel = 64'(t_r);    b_sel = 64'(hoo_r);  end
      OP_TV:   begin a_sel = 64'(t_r);    b_sel = 64'(vmag_r); end
      OP_DHH:  begin a_sel = 64'(hhoo_r); b_sel = 64'(dmag_r); end
      OP_DHO:  begin a_sel = 64'(hoo_r);  b_sel = 64'(dmag_r); end
      default: begin a_sel = '0;          b_sel = '0;          end
    endcase
    a_half = mcnt_r[1] ? a_sel[63:32] : a_sel[31:0];
    b_half = mcnt_r[0] ? b_sel[63:32] : b_sel[31:0];
    case (sh_r)
      2'd0:    pp_ext = ACC_W'(prod_r);
      2'd1:    pp_ext = ACC_W'(prod_r) << 32;
      default: pp_ext = ACC_W'(prod_r) << 64;
    endcase
    mul_done = mbusy_r && (mcnt_r == 3'd5);
    // warped step 0.5h + 1.5h^2 - h^3 in q0.48
    t48 = (50'(h_r) << 31) + ((50'(h2_r) + (50'(h2_r) << 1)) << 15) - 50'(acc_r[47:0]);
  end

  // four partial products, each accumulated in the cycle after it is formed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      mcnt_r  <= '0;
      mop_r   <= OP_HH;
    end else if (cmd.mul_start) begin
      mbusy_r <= 1'b1;
      mcnt_r  <= '0;
      mop_r   <= cmd.mul_op;
      acc_r   <= '0;
    end else if (mbusy_r) begin
      if (mcnt_r < 3'd4) begin
        prod_r <= a_half * b_half;
        sh_r   <= 2'(mcnt_r[0]) + 2'(mcnt_r[1]);
      end
      if (mcnt_r != 3'd0 && mcnt_r != 3'd5) acc_r <= acc_r + pp_ext;
      if (mcnt_r == 3'd5) mbusy_r <= 1'b0;
      else mcnt_r <= mcnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_done) begin
      case (mop_r)
        OP_HH:   h2_r  <= acc_r[31:0];
        OP_HHH:  t_r   <= t48[47:32];
        OP_TZ:   tz_r  <= acc_r[35:0];
        OP_TZO:  f_r   <= (DET_W'(1) << 32) + DET_W'(acc_r[59:15]);
        OP_OO:   oo_r  <= acc_r[47:0];
        OP_HOO:  hoo_r <= acc_r[63:16];
        OP_HHOO: begin
          hhoo_r <= acc_r[63:16];
          det_r  <= f_r + DET_W'(acc_r[63:16]);
        end
        OP_TV:   tv_r <= v_neg_r ? -(NUM_W'(acc_r[47:0]) << 16) : NUM_W'(acc_r[47:0]) << 16;
        OP_DHH:  dh_r <= d_neg_r ? -NUM_W'(acc_r[80:0]) : NUM_W'(acc_r[80:0]);
        OP_DHO:  do_r <= d_neg_r ? -NUM_W'(acc_r[80:0]) : NUM_W'(acc_r[80:0]);
        default: ;
      endcase
    end
  end

  assign dd = 33'(in_target) - 33'(in_position_in);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= in_position_in;
      h_r     <= in_time_step;
      d_neg_r <= dd[32];
      dmag_r  <= dd[32] ? 33'(-dd) : 33'(dd);
      v_neg_r <= vel_r[31];
      vmag_r  <= vel_r[31] ? 32'(-vel_r) : 32'(vel_r);
    end
    if (cmd.num_load) begin
      nx_r <= tv_r + dh_r;
      nv_r <= (NUM_W'(vel_r) <<< 32) + do_r;
    end
  end

  always_comb begin
    num_sel  = cmd.div_sel ? nv_r : nx_r;
    num_abs  = num_sel[NUM_W-1] ? -num_sel : num_sel;
    q_signed = nneg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

  sdis_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .num_mag (num_abs[MAG_W-1:0]),
    .den     (det_r),
    .done    (div_done),
    .quo     (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) nneg_r <= num_sel[NUM_W-1];
    if (cmd.div_store) begin
      if (cmd.div_sel) qv_r <= q_signed;
      else qx_r <= q_signed;
    end
  end

  // saturate to the 32-bit signed range
  always_comb begin
    pos_sum = SUM_W'(x_r) + SUM_W'(qx_r);
    vel_ext = SUM_W'(qv_r);
    pos_ovf = (pos_sum[SUM_W-1:31] != '0) && (pos_sum[SUM_W-1:31] != '1);
    vel_ovf = (vel_ext[SUM_W-1:31] != '0) && (vel_ext[SUM_W-1:31] != '1);
    pos_sat = pos_ovf ? (pos_sum[SUM_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff) : pos_sum[31:0];
    vel_sat = vel_ovf ? (vel_ext[SUM_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff) : vel_ext[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_r <= '0;
    end else if (cmd.finish) begin
      vel_r <= vel_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      pos_out_r <= pos_sat;
      vel_out_r <= vel_sat;
      clamp_r   <= pos_ovf || vel_ovf;
    end
  end

  assign stat.mul_done    = mul_done;
  assign stat.div_done    = div_done;
  assign out_position_out = pos_out_r;
  assign out_velocity_out = vel_out_r;
  assign out_clamped      = clamp_r;
endmodule

// ----- src/spring_damper_implicit_step.sv -----
// top level of the implicit-euler spring-damper step
// depends on sdis_pkg, sdis_ctrl, sdis_dp and the assertion macro header
//
//  channel  ports                                   handshake
//  in       in_position_in, in_target, in_time_step  in_valid / in_ready
//  out      out_position_out, out_velocity_out,      out_valid / out_ready
//           out_clamped
//  config   psel penable pwrite paddr pwdata prdata  apb, pready tied high
//
// one word runs ten products on one shared 32x32 multiplier, then two
// radix-2 divides through the one divider, which take most of the time
// synchronous active-low reset clears the sequencer, the stored velocity and
// restores zeta and omega to 1.0
// a new word is taken while the previous result still waits on out_ready;
// only the final write of the output register waits for it
`include "spring_damper_implicit_step_macros.svh"

module spring_damper_implicit_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_position_in,
  input  logic signed [31:0] in_target,
  input  logic [15:0]        in_time_step,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_position_out,
  output logic signed [31:0] out_velocity_out,
  output logic               out_clamped,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import sdis_pkg::*;

  logic [19:0] zeta_r;
  logic [23:0] omega_r;
  logic        reg_idx;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  // registers sit on word addresses, index is the word number
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zeta_r  <= 20'd65536;
      omega_r <= 24'd65536;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_ZETA:  zeta_r  <= pwdata[19:0];
        REG_OMEGA: omega_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ZETA:  prdata = 32'(zeta_r);
      REG_OMEGA: prdata = 32'(omega_r);
      default:   prdata = '0;
    endcase
  end

  // sequencer
  sdis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // arithmetic and the stored velocity
  sdis_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_position_in   (in_position_in),
    .in_target        (in_target),
    .in_time_step     (in_time_step),
    .zeta             (zeta_r),
    .omega            (omega_r),
    .out_position_out (out_position_out),
    .out_velocity_out (out_velocity_out),
    .out_clamped      (out_clamped)
  );

  // a taken word keeps the block busy
  `SDIS_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "ready after take")
  // a result appears only at the end of a computation
  `SDIS_ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(!in_ready), "result without work")
  // a clamp flag means at least one result sits on a rail
  `SDIS_ASSERT_SAME(a_clamp_on_rail, out_valid && out_clamped,
    out_position_out == 32'sh7fff_ffff || out_position_out == 32'sh8000_0000 ||
    out_velocity_out == 32'sh7fff_ffff || out_velocity_out == 32'sh8000_0000,
    "clamp off rail")

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for the implicit-euler spring-damper step block
// depends on sdis_pkg and the spring_damper_implicit_step rtl
`timescale 1ns / 100ps

module tb_top;
  import sdis_pkg::*;

  // one input word: position, target, step
  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] tgt;
    logic [15:0]        dt;
  } step_in_t;

  // one result word
  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic               clamp;
  } step_out_t;

  // register byte addresses, register i at 4*i
  localparam logic [2:0] ADDR_ZETA  = {REG_ZETA, 2'b00};
  localparam logic [2:0] ADDR_OMEGA = {REG_OMEGA, 2'b00};

  localparam int LIMIT_CYCLES = 5_000_000;
  localparam int DRAIN_CYCLES = 400;

  localparam logic signed [129:0] SAT_MAX = 2147483647;
  localparam logic signed [129:0] SAT_MIN = -SAT_MAX - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_position_in = '0;
  logic signed [31:0] in_target = '0;
  logic [15:0]        in_time_step = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_position_out;
  logic signed [31:0] out_velocity_out;
  logic               out_clamped;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  spring_damper_implicit_step u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_position_in(in_position_in), .in_target(in_target),
    .in_time_step(in_time_step),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_position_out(out_position_out), .out_velocity_out(out_velocity_out),
    .out_clamped(out_clamped),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // bench copy of the block state and registers
  logic [19:0]        zeta_q = 20'd65536;
  logic [23:0]        omega_q = 24'd65536;
  logic signed [31:0] vel_q = '0;

  step_in_t  pending_q[$];
  step_out_t expected_q[$];
  int        send_idle = 29;   // percent of cycles the sender holds off
  int        recv_idle = 59;   // percent of cycles the receiver stalls
  int        fails = 0;
  int        cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // saturate a wide signed value to 32 bits, flag the clamp
  function automatic logic signed [31:0] clamp32(input logic signed [129:0] v,
                                                 inout logic hit);
    if (v > SAT_MAX) begin
      hit = 1'b1;
      return SAT_MAX[31:0];
    end
    if (v < SAT_MIN) begin
      hit = 1'b1;
      return SAT_MIN[31:0];
    end
    return v[31:0];
  endfunction

  // implicit-euler step: warp the step, build the shared determinant,
  // divide both numerators and update the stored velocity
  function automatic step_out_t spring_step(input step_in_t w);
    logic [63:0]        hw, h2, h3, t48, t, f, oo, hoo, hhoo, det;
    logic signed [129:0] xw, xtw, vw, dw, nx, nv, detw;
    logic               hit;
    step_out_t          r;
    hw   = w.dt;
    h2   = hw * hw;
    h3   = h2 * hw;
    // 0.5h + 1.5h^2 - h^3 exactly in q0.48, then cut to q0.16
    t48  = (hw << 31) + ((64'd3 * h2) << 15) - h3;
    t    = t48 >> 32;
    f    = (64'd1 << 32) + ((t * zeta_q * omega_q) >> 15);
    oo   = omega_q * omega_q;
    hoo  = (t * oo) >> 16;
    hhoo = (t * hoo) >> 16;
    det  = f + hhoo;
    xw   = w.pos;
    xtw  = w.tgt;
    vw   = vel_q;
    dw   = xtw - xw;
    nx   = $signed({66'd0, t << 16}) * vw + $signed({66'd0, hhoo}) * dw;
    nv   = (vw <<< 32) + $signed({66'd0, hoo}) * dw;
    detw = $signed({66'd0, det});
    hit  = 1'b0;
    // signed division truncates toward zero, det is always positive
    r.pos   = clamp32(xw + nx / detw, hit);
    r.vel   = clamp32(nv / detw, hit);
    r.clamp = hit;
    vel_q   = r.vel;
    return r;
  endfunction

  // sender: holds the word until taken, then maybe idles
  always @(posedge clk) begin
    step_in_t nxt;
    if (rst_n && !(in_valid && !in_ready)) begin
      if (in_valid)
        expected_q.push_back(spring_step('{in_position_in, in_target, in_time_step}));
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        nxt = pending_q.pop_front();
        in_position_in <= nxt.pos;
        in_target      <= nxt.tgt;
        in_time_step   <= nxt.dt;
        in_valid       <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, compare each word with the oldest prediction
  always @(posedge clk) begin
    step_out_t e;
    cycles <= cycles + 1;
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle);
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result word with no prediction waiting");
        fails++;
      end else begin
        e = expected_q.pop_front();
        if (out_position_out !== e.pos) begin
          $error("position_out expected %0d actual %0d", e.pos, out_position_out);
          fails++;
        end
        if (out_velocity_out !== e.vel) begin
          $error("velocity_out expected %0d actual %0d", e.vel, out_velocity_out);
          fails++;
        end
        if (out_clamped !== e.clamp) begin
          $error("clamped expected %0b actual %0b", e.clamp, out_clamped);
          fails++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // apb write with setup and access phases, bench copy follows
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_ZETA) zeta_q = data[19:0];
    else omega_q = data[23:0];
  endtask

  // wait until every word is sent and every result is in
  task automatic drain;
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_word(input logic [31:0] p, input logic [31:0] g,
                          input logic [15:0] s);
    pending_q.push_back('{p, g, s});
  endtask

  // random words: mostly moderate values, some full-range
  task automatic add_random(input int n);
    logic [31:0] p, g;
    repeat (n) begin
      case ($urandom_range(3))
        0: begin
          p = $urandom;
          g = $urandom;
        end
        1: begin
          p = $signed($urandom_range(2000000)) - 1000000;
          g = p + $signed($urandom_range(200000)) - 100000;
        end
        default: begin
          p = $signed($urandom_range(20000000)) - 10000000;
          g = $signed($urandom_range(20000000)) - 10000000;
        end
      endcase
      add_word(p, g, $urandom_range(65535));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero step, full step, field extremes, large jumps
    reg_write(ADDR_ZETA, 32'd65536);
    reg_write(ADDR_OMEGA, 32'd65536);
    add_word(32'sd0, 32'sd0, 16'd0);
    add_word(32'sd65536, 32'sd0, 16'd0);
    add_word(32'sd0, 32'sd655360, 16'd65535);
    add_word(32'sd0, 32'sd655360, 16'd32768);
    add_word(32'h7FFFFFFF, 32'h80000000, 16'd65535);
    add_word(32'h80000000, 32'h7FFFFFFF, 16'd65535);
    add_word(32'h7FFFFFFF, 32'h7FFFFFFF, 16'd1);
    add_word(32'h80000000, 32'h80000000, 16'hFFFF);
    add_word(32'hFFFFFFFF, 32'h00000001, 16'h5555);
    add_word(32'h55555555, 32'hAAAAAAAA, 16'hAAAA);
    add_random(240);
    drain();

    // extremes of both registers, the overflow corner
    send_idle = 59;
    recv_idle = 29;
    reg_write(ADDR_ZETA, 32'hFFFFF);
    reg_write(ADDR_OMEGA, 32'hFFFFFF);
    add_word(32'h80000000, 32'h7FFFFFFF, 16'd65535);
    add_word(32'sd0, 32'sd1, 16'd1);
    add_word(32'sd0, 32'sd0, 16'd0);
    add_random(120);
    drain();

    reg_write(ADDR_ZETA, 32'd0);
    reg_write(ADDR_OMEGA, 32'd0);
    add_word(32'sd100, 32'sd5000, 16'd65535);
    add_random(120);
    drain();

    // no idling, random mid-range settings
    send_idle = 0;
    recv_idle = 0;
    repeat (4) begin
      reg_write(ADDR_ZETA, $urandom_range(200000, 10000));
      reg_write(ADDR_OMEGA, $urandom_range(2000000, 30000));
      add_random(100);
      drain();
    end

    if (fails == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/sdis_pkg.sv
src/sdis_div.sv
src/sdis_ctrl.sv
src/sdis_dp.sv
src/spring_damper_implicit_step.sv
bench/tb_top.sv
